// ===== hdl/bald_pkg.sv =====
// Package for the bounded deque: sizes, opcode and status codes, payload structs,
// sequencer states and the ring-index helpers.
// Depends on nothing; every other file of the block imports it.
package bald_pkg;

	localparam int CAPACITY     = 64;
	localparam int ELEMENT_BITS = 32;
	localparam int PTR_BITS     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS     = $clog2(CAPACITY + 1);

	// Fixed field widths of the request and result.
	localparam int OPC_BITS  = 3;
	localparam int DATA_BITS = 32;
	localparam int POS_BITS  = 6;
	localparam int COUNT_W   = 7;
	localparam int STAT_BITS = 2;

	localparam logic [OPC_BITS-1:0] OP_INS_HEAD = 3'd0;
	localparam logic [OPC_BITS-1:0] OP_INS_TAIL = 3'd1;
	localparam logic [OPC_BITS-1:0] OP_REM_HEAD = 3'd2;
	localparam logic [OPC_BITS-1:0] OP_REM_TAIL = 3'd3;
	localparam logic [OPC_BITS-1:0] OP_READ     = 3'd4;

	localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_BITS-1:0] STAT_RANGE = 2'd3;

	typedef struct packed {
		logic [OPC_BITS-1:0]  opcode;
		logic [DATA_BITS-1:0] elem_data;
		logic [POS_BITS-1:0]  position;
	} request_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] read_data;
		logic [DATA_BITS-1:0] head_data;
		logic [DATA_BITS-1:0] tail_data;
		logic [COUNT_W-1:0]   count;
		logic [STAT_BITS-1:0] status;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DONE
	} state_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic finish;
	} cmd_t;

	// Where the word fetched during execution goes when the result is formed.
	typedef enum logic [1:0] {
		RS_NONE,
		RS_HEAD,
		RS_TAIL,
		RS_READ
	} rdsel_t;

	// (base + off) modulo CAPACITY, for off < CAPACITY and base < CAPACITY.
	function automatic logic [PTR_BITS-1:0] ring_add(input logic [PTR_BITS-1:0] base,
		input logic [PTR_BITS:0] off);
		logic [PTR_BITS+1:0] sum;
		sum = {2'b00, base} + {1'b0, off};
		if (sum >= (PTR_BITS+2)'(CAPACITY)) begin
			sum = sum - (PTR_BITS+2)'(CAPACITY);
		end
		return sum[PTR_BITS-1:0];
	endfunction

	function automatic logic [PTR_BITS-1:0] ring_dec(input logic [PTR_BITS-1:0] base);
		logic [PTR_BITS-1:0] r;
		if (base == '0) begin
			r = PTR_BITS'(CAPACITY - 1);
		end else begin
			r = base - PTR_BITS'(1);
		end
		return r;
	endfunction

endpackage

// ===== hdl/bald_ctrl.sv =====
// Sequencer of the bounded deque: idle, execute and done states.
// Depends on bald_pkg for the state enum and the command struct.
module bald_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output bald_pkg::cmd_t cmd
);
	import bald_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (start) state_d = ST_EXEC;
				else state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy       = 1'b0;
		done       = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			ST_DONE: begin
				done       = 1'b1;
				cmd.finish = 1'b1;
				cmd.load   = start;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

// ===== hdl/bald_dpath.sv =====
// Datapath of the bounded deque: element ring memory, head pointer, count,
// cached head and tail words and the result formation.
// Depends on bald_pkg for sizes, codes, structs and ring helpers.
module bald_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  bald_pkg::cmd_t     cmd,
	input  bald_pkg::request_t request,
	output bald_pkg::result_t  result
);
	import bald_pkg::*;

	logic [ELEMENT_BITS-1:0] mem [CAPACITY];

	request_t                req_q;
	logic [PTR_BITS-1:0]     head_ptr_q;
	logic [CNT_BITS-1:0]     count_q;
	logic [ELEMENT_BITS-1:0] head_q;
	logic [ELEMENT_BITS-1:0] tail_q;
	logic [ELEMENT_BITS-1:0] rdata_q;
	logic [STAT_BITS-1:0]    status_q;
	rdsel_t                  sel_q;

	logic                    full;
	logic                    empty;
	logic [ELEMENT_BITS-1:0] wdata;
	logic                    wr_en;
	logic [PTR_BITS-1:0]     wr_addr;
	logic [PTR_BITS-1:0]     rd_addr;
	logic [PTR_BITS-1:0]     head_ptr_d;
	logic [CNT_BITS-1:0]     count_d;
	logic [ELEMENT_BITS-1:0] head_d;
	logic [ELEMENT_BITS-1:0] tail_d;
	logic [STAT_BITS-1:0]    status_d;
	rdsel_t                  sel_d;
	logic [ELEMENT_BITS-1:0] head_now;
	logic [ELEMENT_BITS-1:0] tail_now;

	assign full  = (count_q == CNT_BITS'(CAPACITY));
	assign empty = (count_q == '0);
	assign wdata = ELEMENT_BITS'(req_q.elem_data);

	// Decode of the latched request against the current list.
	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = head_ptr_q;
		rd_addr    = head_ptr_q;
		head_ptr_d = head_ptr_q;
		count_d    = count_q;
		head_d     = head_q;
		tail_d     = tail_q;
		status_d   = STAT_OK;
		sel_d      = RS_NONE;
		case (req_q.opcode)
			OP_INS_HEAD: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					head_ptr_d = ring_dec(head_ptr_q);
					wr_en      = 1'b1;
					wr_addr    = head_ptr_d;
					count_d    = count_q + CNT_BITS'(1);
					head_d     = wdata;
					if (empty) tail_d = wdata;
				end
			end
			OP_INS_TAIL: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = ring_add(head_ptr_q, (PTR_BITS+1)'(count_q));
					count_d = count_q + CNT_BITS'(1);
					tail_d  = wdata;
					if (empty) head_d = wdata;
				end
			end
			OP_REM_HEAD: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					head_ptr_d = ring_add(head_ptr_q, (PTR_BITS+1)'(1));
					rd_addr    = head_ptr_d;
					count_d    = count_q - CNT_BITS'(1);
					if (count_q > CNT_BITS'(1)) sel_d = RS_HEAD;
				end
			end
			OP_REM_TAIL: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					count_d = count_q - CNT_BITS'(1);
					if (count_q > CNT_BITS'(1)) begin
						rd_addr = ring_add(head_ptr_q, (PTR_BITS+1)'(count_q - CNT_BITS'(2)));
						sel_d   = RS_TAIL;
					end
				end
			end
			OP_READ: begin
				if ((CNT_BITS+POS_BITS)'(req_q.position) >= (CNT_BITS+POS_BITS)'(count_q)) begin
					status_d = STAT_RANGE;
				end else begin
					rd_addr = ring_add(head_ptr_q, (PTR_BITS+1)'(req_q.position));
					sel_d   = RS_READ;
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	// Ring memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (wr_en) mem[wr_addr] <= wdata;
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= request;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			count_q    <= '0;
			status_q   <= STAT_OK;
			sel_q      <= RS_NONE;
		end else if (cmd.exec) begin
			head_ptr_q <= head_ptr_d;
			count_q    <= count_d;
			status_q   <= status_d;
			sel_q      <= sel_d;
		end
	end

	assign head_now = (sel_q == RS_HEAD) ? rdata_q : head_q;
	assign tail_now = (sel_q == RS_TAIL) ? rdata_q : tail_q;

	// Cached end words; a fetched word lands here when the result goes out.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			head_q <= head_d;
			tail_q <= tail_d;
		end else if (cmd.finish) begin
			head_q <= head_now;
			tail_q <= tail_now;
		end
	end

	always_comb begin
		result           = '0;
		result.count     = COUNT_W'(count_q);
		result.status    = status_q;
		if (sel_q == RS_READ) result.read_data = DATA_BITS'(rdata_q);
		if (count_q != '0) begin
			result.head_data = DATA_BITS'(head_now);
			result.tail_data = DATA_BITS'(tail_now);
		end
	end

endmodule

// ===== hdl/bounded_array_list_deque.sv =====
// Bounded deque with indexed read. A transferred request is latched, executed
// in the execute state and answered with done high in the done state. A new
// request is taken in the done state, as the result is shown, but not while
// executing. Reset clears the head pointer, count and sequencer at once;
// the ring memory is not cleared and needs no clearing pass. The receiver
// cannot stall, so done is a one-cycle strobe.
module bounded_array_list_deque (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bald_pkg::request_t request,
	output logic               busy,
	output logic               done,
	output bald_pkg::result_t  result
);
	import bald_pkg::*;

	// The sequencer and the datapath talk only through this command bundle.
	cmd_t cmd;

	// The controller accepts a transfer in its idle state and also in its done
	// state, so a new request overlaps the cycle in which the previous result
	// is shown. busy is high only during the execute cycle.
	bald_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// The datapath keeps the list as a ring with a head pointer. An insert is a
	// single write plus a count update (and a pointer update at the head); a
	// remove or a read needs one memory read, whose word is merged into the
	// result in the done cycle. Head and tail words are cached so inserts need no read.
	bald_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.result  (result)
	);

endmodule

// ===== hdl/bald_checker.sv =====
// Port-level checker for the bounded deque, attached to the top level by bind.
// Depends on bald_pkg for codes and the payload structs.
module bald_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input bald_pkg::result_t  result
);
	import bald_pkg::*;

	a_resp_two: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result not delivered two cycles after transfer");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.count == '0) |-> (result.head_data == '0 && result.tail_data == '0))
		else $error("empty list reports nonzero end words");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STAT_FULL) |-> (result.count == COUNT_W'(CAPACITY)))
		else $error("full status with list not full");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_OK) |-> (result.read_data == '0))
		else $error("flagged result carries read data");

endmodule

bind bounded_array_list_deque bald_checker u_bald_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);

// ===== dv/bald_deque_checker.sv =====
// Checker for the bounded deque: watches the request and result channels, keeps
// its own copy of the list and compares every result field by field.
// Depends on bald_pkg for the payload structs, sizes and codes.
`timescale 1ns / 100ps

module bald_deque_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  bald_pkg::request_t request,
	input  logic               done,
	input  bald_pkg::result_t  result,
	output int                 errors,
	output int                 outstanding,
	output int                 checked,
	output int                 peak_fill,
	output int                 full_hits,
	output int                 empty_hits,
	output int                 range_hits
);
	import bald_pkg::*;

	localparam logic [DATA_BITS-1:0] ELEM_MASK = (ELEMENT_BITS >= DATA_BITS) ?
		{DATA_BITS{1'b1}} : DATA_BITS'((64'd1 << ELEMENT_BITS) - 64'd1);
	localparam int PRINT_CAP = 25;

	// Shadow list: a ring with a front index and a fill level.
	logic [DATA_BITS-1:0] ring [CAPACITY];
	int front;
	int fill;

	result_t due_results [$];

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= PRINT_CAP) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	// Applies one request to the shadow list and forms the answer it should get.
	task automatic deque_step(input request_t req, output result_t ans);
		ans = '0;
		case (req.opcode)
			OP_INS_HEAD: begin
				if (fill >= CAPACITY) begin
					ans.status = STAT_FULL;
				end else begin
					front = (front + CAPACITY - 1) % CAPACITY;
					ring[front] = req.elem_data & ELEM_MASK;
					fill++;
				end
			end
			OP_INS_TAIL: begin
				if (fill >= CAPACITY) begin
					ans.status = STAT_FULL;
				end else begin
					ring[(front + fill) % CAPACITY] = req.elem_data & ELEM_MASK;
					fill++;
				end
			end
			OP_REM_HEAD: begin
				if (fill == 0) begin
					ans.status = STAT_EMPTY;
				end else begin
					front = (front + 1) % CAPACITY;
					fill--;
				end
			end
			OP_REM_TAIL: begin
				if (fill == 0) begin
					ans.status = STAT_EMPTY;
				end else begin
					fill--;
				end
			end
			OP_READ: begin
				if (int'(req.position) >= fill) begin
					ans.status = STAT_RANGE;
				end else begin
					ans.read_data = ring[(front + int'(req.position)) % CAPACITY];
				end
			end
			default: begin
				// Spare opcodes leave the list alone and report it as it is.
			end
		endcase
		if (fill != 0) begin
			ans.head_data = ring[front];
			ans.tail_data = ring[(front + fill - 1) % CAPACITY];
		end
		ans.count = COUNT_W'(fill);
	endtask

	task automatic compare_result(input result_t want, input result_t got);
		if (got.read_data !== want.read_data) begin
			report_mismatch($sformatf("read_data %h, expected %h", got.read_data,
				want.read_data));
		end
		if (got.head_data !== want.head_data) begin
			report_mismatch($sformatf("head_data %h, expected %h", got.head_data,
				want.head_data));
		end
		if (got.tail_data !== want.tail_data) begin
			report_mismatch($sformatf("tail_data %h, expected %h", got.tail_data,
				want.tail_data));
		end
		if (got.count !== want.count) begin
			report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
		end
		if (got.status !== want.status) begin
			report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
		end
	endtask

	initial begin
		errors      = 0;
		outstanding = 0;
		checked     = 0;
		peak_fill   = 0;
		full_hits   = 0;
		empty_hits  = 0;
		range_hits  = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t next_ans;
		if (!arst_n) begin
			front = 0;
			fill  = 0;
			due_results.delete();
			outstanding <= 0;
		end else begin
			if (done === 1'b1) begin
				if (due_results.size() == 0) begin
					report_mismatch("result strobe with no request waiting");
				end else begin
					want = due_results.pop_front();
					compare_result(want, result);
					checked++;
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				deque_step(request, next_ans);
				due_results.push_back(next_ans);
				if (fill > peak_fill) begin
					peak_fill = fill;
				end
				case (next_ans.status)
					STAT_FULL:  full_hits++;
					STAT_EMPTY: empty_hits++;
					STAT_RANGE: range_hits++;
					default: begin
					end
				endcase
			end
			outstanding <= due_results.size();
		end
	end

endmodule

// ===== dv/bounded_array_list_deque_tb.sv =====
// Testbench top for the bounded deque: clock, reset, directed and random
// requests under three idle profiles, and the final verdict.
// Depends on bald_pkg, the block and dv/bald_deque_checker.sv.
`timescale 1ns / 100ps

module bounded_array_list_deque_tb;
	import bald_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 3;
	localparam int RANDOM_ITEMS = 628;
	// The drain wait runs on once no result is outstanding.
	localparam int DRAIN_CYCLES = 8;
	// The watchdog limit is far above what an honest run needs, so it is generous.
	localparam int CYCLE_LIMIT  = 200000;

	// Opcodes that the block leaves unused; they must report the list unchanged.
	localparam logic [OPC_BITS-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OPC_BITS-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OPC_BITS-1:0] OP_SPARE_7 = 3'd7;

	// Stimulus moods: each one biases the opcode mix so that long random runs
	// actually fill the list to capacity, read across it and drain it again.
	typedef enum logic [1:0] {
		MODE_FILL,
		MODE_READ,
		MODE_DRAIN,
		MODE_MIXED
	} mood_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	request_t request = '0;
	logic     busy;
	logic     done;
	result_t  result;

	int errors;
	int outstanding;
	int checked;
	int peak_fill;
	int full_hits;
	int empty_hits;
	int range_hits;

	int cycles = 0;
	int sent = 0;
	int directed_sent = 0;
	int gap_pct = 0;

	always #(HALF_PERIOD) clk = ~clk;

	bounded_array_list_deque u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	bald_deque_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.done        (done),
		.result      (result),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.peak_fill   (peak_fill),
		.full_hits   (full_hits),
		.empty_hits  (empty_hits),
		.range_hits  (range_hits)
	);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic request_t make_req(input logic [OPC_BITS-1:0] op,
		input logic [DATA_BITS-1:0] data, input logic [POS_BITS-1:0] pos);
		request_t r;
		r.opcode    = op;
		r.elem_data = data;
		r.position  = pos;
		return r;
	endfunction

	// Holds start high until the block takes the transfer, then idles the
	// sender for a random number of cycles according to gap_pct. Because the
	// gap is drawn per cycle, the next start lands on any phase of the block's
	// execute and done states, and with gap_pct at zero start simply stays high.
	task automatic send_request(input request_t req);
		request_t junk;
		start   <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy !== 1'b0) begin
			@(posedge clk);
		end
		sent++;
		while ($urandom_range(0, 99) < gap_pct) begin
			junk = make_req(OPC_BITS'($urandom), $urandom, POS_BITS'($urandom));
			start   <= 1'b0;
			request <= junk;
			@(posedge clk);
		end
	endtask

	// Element words: mostly random, with the all-zero and all-one words now and then.
	function automatic logic [DATA_BITS-1:0] pick_data();
		logic [DATA_BITS-1:0] d;
		case ($urandom_range(0, 7))
			0: d = '0;
			1: d = '1;
			default: d = $urandom;
		endcase
		return d;
	endfunction

	function automatic request_t pick_request(input mood_t mood);
		int roll;
		int ins_h;
		int ins_t;
		int rem_h;
		int rem_t;
		int rd;
		logic [OPC_BITS-1:0] op;
		logic [POS_BITS-1:0] pos;
		// Cumulative thresholds out of 100; what is left goes to spare opcodes.
		case (mood)
			MODE_FILL:  begin ins_h = 40; ins_t = 75; rem_h = 82; rem_t = 88; rd = 97; end
			MODE_DRAIN: begin ins_h = 5;  ins_t = 10; rem_h = 45; rem_t = 80; rd = 95; end
			MODE_READ:  begin ins_h = 8;  ins_t = 16; rem_h = 21; rem_t = 26; rd = 98; end
			default:    begin ins_h = 20; ins_t = 40; rem_h = 60; rem_t = 80; rd = 97; end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < ins_h) begin
			op = OP_INS_HEAD;
		end else if (roll < ins_t) begin
			op = OP_INS_TAIL;
		end else if (roll < rem_h) begin
			op = OP_REM_HEAD;
		end else if (roll < rem_t) begin
			op = OP_REM_TAIL;
		end else if (roll < rd) begin
			op = OP_READ;
		end else begin
			op = OPC_BITS'($urandom_range(OP_SPARE_5, OP_SPARE_7));
		end
		// Half the reads aim near the head where they usually hit, half range
		// over every position so the far end and out-of-range reads both occur.
		if ($urandom_range(0, 1) == 0) begin
			pos = POS_BITS'($urandom_range(0, 15));
		end else begin
			pos = POS_BITS'($urandom);
		end
		return make_req(op, pick_data(), pos);
	endfunction

	initial begin
		request_t directed [$];
		mood_t mood;
		int seg_left;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase one: gap_pct is 30, the chance in a hundred that the sender idles on.
		gap_pct = 30;

		// Directed part. The empty list first: out-of-range read, both removes
		// flagged empty, and the spare opcodes. Then a short list built from
		// both ends with extreme words, reads at both ends and past them, and
		// a drain back to empty with one more remove on the empty list.
		directed.push_back(make_req(OP_READ,     '0,           '0));
		directed.push_back(make_req(OP_REM_HEAD, '1,           '1));
		directed.push_back(make_req(OP_REM_TAIL, '0,           '0));
		directed.push_back(make_req(OP_SPARE_5,  '1,           '1));
		directed.push_back(make_req(OP_SPARE_6,  32'h1234_5678, 6'd5));
		directed.push_back(make_req(OP_SPARE_7,  '0,           '0));
		directed.push_back(make_req(OP_INS_TAIL, '1,           '0));
		directed.push_back(make_req(OP_INS_HEAD, '0,           '1));
		directed.push_back(make_req(OP_INS_HEAD, 32'hA5A5_A5A5, '0));
		directed.push_back(make_req(OP_INS_TAIL, 32'h5A5A_5A5A, '0));
		directed.push_back(make_req(OP_READ,     '1,           6'd0));
		directed.push_back(make_req(OP_READ,     '0,           6'd3));
		directed.push_back(make_req(OP_READ,     '0,           6'd4));
		directed.push_back(make_req(OP_READ,     '0,           6'd63));
		directed.push_back(make_req(OP_SPARE_5,  32'hDEAD_BEEF, 6'd1));
		directed.push_back(make_req(OP_REM_TAIL, '0,           '0));
		directed.push_back(make_req(OP_REM_HEAD, '0,           '0));
		directed.push_back(make_req(OP_READ,     '0,           6'd1));
		directed.push_back(make_req(OP_REM_HEAD, '0,           '0));
		directed.push_back(make_req(OP_REM_TAIL, '0,           '0));
		directed.push_back(make_req(OP_REM_TAIL, '0,           '0));
		directed.push_back(make_req(OP_INS_HEAD, 32'h8000_0001, '0));
		foreach (directed[i]) begin
			send_request(directed[i]);
		end
		directed_sent = directed.size();

		// Random part: moods run in segments long enough that a fill segment
		// from near empty reaches capacity and then keeps pushing into a full
		// list, and a drain segment keeps pulling from an empty one.
		mood = MODE_MIXED;
		seg_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Phase two: gap_pct is 86, so the sender idles far more often.
			// Phase three: it never idles, so transfers run back to back.
			if (i == RANDOM_ITEMS / 3) begin
				gap_pct = 86;
			end else if (i == 2 * RANDOM_ITEMS / 3) begin
				gap_pct = 0;
			end
			if (seg_left == 0) begin
				case (mood)
					MODE_MIXED: begin mood = MODE_FILL;  seg_left = $urandom_range(110, 150); end
					MODE_FILL:  begin mood = MODE_READ;  seg_left = $urandom_range(20, 40);   end
					MODE_READ:  begin mood = MODE_DRAIN; seg_left = $urandom_range(110, 150); end
					default:    begin mood = MODE_MIXED; seg_left = $urandom_range(30, 60);   end
				endcase
			end
			send_request(pick_request(mood));
			seg_left--;
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d directed, %0d random) under three sender idle profiles;",
			sent, directed_sent, sent - directed_sent);
		$display("checked %0d results: %0d full, %0d empty, %0d out-of-range, peak fill %0d.",
			checked, full_hits, empty_hits, range_hits, peak_fill);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
